### src/pixel_format_to_bgr_converter_core_macros.svh
// Assertion macros for the pixel format converter.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef PIXEL_FORMAT_TO_BGR_CONVERTER_CORE_MACROS_SVH
`define PIXEL_FORMAT_TO_BGR_CONVERTER_CORE_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define PFBGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define PFBGR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### src/pfbgr_pkg.sv
// Package for the pixel format converter: types, constants and helper functions.
// No dependencies.
`timescale 1ns / 1ps

package pfbgr_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int PAL_WIDTH     = 24;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] REG_FORMAT      = 2'd0;
  localparam logic [1:0] REG_RED_MASK    = 2'd1;
  localparam logic [1:0] REG_GREEN_MASK  = 2'd2;
  localparam logic [1:0] REG_BLUE_MASK   = 2'd3;

  typedef enum logic [1:0] {
    FMT_PAL8  = 2'd0,
    FMT_RGB16 = 2'd1,
    FMT_RGB24 = 2'd2,
    FMT_RGB32 = 2'd3
  } fmt_e;

  typedef struct packed {
    logic [31:0] mask;
    logic [4:0]  sh32;
    logic [3:0]  sh16;
    logic        is5;
  } chan_cfg_t;

  typedef struct packed {
    logic                 pal_ok;
    logic [31:0]          pixel;
    logic [PAL_WIDTH-1:0] rgb;
  } item_t;

  function automatic logic [4:0] lsb_pos(logic [31:0] m);
    logic [31:0] low;
    logic [4:0]  pos;
    low = m & (~m + 32'd1);
    pos = '0;
    for (int i = 0; i < 32; i++) begin
      if (low[i]) begin
        pos = pos | 5'(i);
      end
    end
    return pos;
  endfunction

  function automatic chan_cfg_t make_chan(logic [31:0] m);
    chan_cfg_t c;
    logic [4:0] s16;
    s16    = lsb_pos({16'h0000, m[15:0]});
    c.mask = m;
    c.sh32 = lsb_pos(m);
    c.sh16 = s16[3:0];
    c.is5  = ((m[15:0] >> s16[3:0]) == 16'h001f);
    return c;
  endfunction

endpackage

### src/pfbgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pfbgr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/pfbgr_front.sv
// Front end: accepts input beats, writes the palette and looks up palette entries.
// Depends on pfbgr_pkg and pfbgr_ram.
`timescale 1ns / 1ps

module pfbgr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic [31:0]           pixel_i,
  input  logic [7:0]            palette_index_i,
  input  logic [7:0]            palette_red_i,
  input  logic [7:0]            palette_green_i,
  input  logic [7:0]            palette_blue_i,
  output logic                  item_valid_o,
  output pfbgr_pkg::item_t      item_o,
  input  logic                  q_full_i
);

  logic        in_acc;
  logic        wr_ok;
  logic        rd_ok;
  logic        f_valid_q;
  logic        pal_ok_q;
  logic [31:0] pixel_q;
  logic [pfbgr_pkg::PAL_WIDTH-1:0] rgb;

  assign in_stall_o = f_valid_q & q_full_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign wr_ok = {1'b0, palette_index_i} < 9'(pfbgr_pkg::PALETTE_DEPTH);
  assign rd_ok = {1'b0, pixel_i[7:0]} < 9'(pfbgr_pkg::PALETTE_DEPTH);

  pfbgr_ram #(
    .WIDTH(pfbgr_pkg::PAL_WIDTH),
    .DEPTH(pfbgr_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (in_acc & action_i & wr_ok),
    .waddr_i(palette_index_i[pfbgr_pkg::PAL_AW-1:0]),
    .wdata_i({palette_red_i, palette_green_i, palette_blue_i}),
    .re_i   (in_acc & ~action_i),
    .raddr_i(pixel_i[pfbgr_pkg::PAL_AW-1:0]),
    .rdata_o(rgb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (in_acc & ~action_i) begin
      f_valid_q <= 1'b1;
    end else if (f_valid_q & ~q_full_i) begin
      f_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc & ~action_i) begin
      pixel_q  <= pixel_i;
      pal_ok_q <= rd_ok;
    end
  end

  assign item_valid_o  = f_valid_q;
  assign item_o.pal_ok = pal_ok_q;
  assign item_o.pixel  = pixel_q;
  assign item_o.rgb    = rgb;

endmodule

### src/pfbgr_queue.sv
// Short queue of conversion items between the front end and the back end.
// Depends on pfbgr_pkg.
`timescale 1ns / 1ps

module pfbgr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pfbgr_pkg::item_t push_data_i,
  input  logic             pop_i,
  output pfbgr_pkg::item_t pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  pfbgr_pkg::item_t                  mem_q [pfbgr_pkg::QUEUE_DEPTH];
  logic [pfbgr_pkg::QUEUE_AW-1:0]    wr_ptr_q;
  logic [pfbgr_pkg::QUEUE_AW-1:0]    rd_ptr_q;
  logic [pfbgr_pkg::QUEUE_AW:0]      cnt_q;
  logic [pfbgr_pkg::QUEUE_AW:0]      cnt_d;

  assign full_o  = cnt_q == (pfbgr_pkg::QUEUE_AW + 1)'(pfbgr_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i & ~pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i & ~push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == pfbgr_pkg::QUEUE_AW'(pfbgr_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == pfbgr_pkg::QUEUE_AW'(pfbgr_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### src/pfbgr_back.sv
// Back end: holds the format and mask registers and converts queued items to BGRA.
// Depends on pfbgr_pkg.
`timescale 1ns / 1ps

module pfbgr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             q_empty_i,
  input  pfbgr_pkg::item_t q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       blue_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       red_out_o,
  output logic [7:0]       alpha_out_o,
  output logic             has_alpha_o
);

  pfbgr_pkg::fmt_e      fmt_q;
  pfbgr_pkg::chan_cfg_t red_q;
  pfbgr_pkg::chan_cfg_t green_q;
  pfbgr_pkg::chan_cfg_t blue_q;

  logic       out_valid_q;
  logic [7:0] blue_out_q, green_out_q, red_out_q, alpha_q;
  logic       has_alpha_q;
  logic [7:0] blue_d, green_d, red_d, alpha_d;
  logic       has_alpha_d;
  logic [31:0] pix_w;

  function automatic logic [7:0] chan_wide(logic [31:0] pix, pfbgr_pkg::chan_cfg_t c);
    logic [31:0] v;
    v = (pix & c.mask) >> c.sh32;
    return v[7:0];
  endfunction

  function automatic logic [7:0] chan16(logic [31:0] pix, pfbgr_pkg::chan_cfg_t c);
    logic [15:0] v;
    v = (pix[15:0] & c.mask[15:0]) >> c.sh16;
    return c.is5 ? {v[4:0], 3'b000} : {v[5:0], 2'b00};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= pfbgr_pkg::FMT_RGB32;
      red_q   <= pfbgr_pkg::make_chan(32'h0000_00ff);
      green_q <= pfbgr_pkg::make_chan(32'h0000_ff00);
      blue_q  <= pfbgr_pkg::make_chan(32'h00ff_0000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfbgr_pkg::REG_FORMAT:     fmt_q   <= pfbgr_pkg::fmt_e'(cfg_data_i[1:0]);
        pfbgr_pkg::REG_RED_MASK:   red_q   <= pfbgr_pkg::make_chan(cfg_data_i);
        pfbgr_pkg::REG_GREEN_MASK: green_q <= pfbgr_pkg::make_chan(cfg_data_i);
        pfbgr_pkg::REG_BLUE_MASK:  blue_q  <= pfbgr_pkg::make_chan(cfg_data_i);
      endcase
    end
  end

  assign q_pop_o = ~q_empty_i & (~out_valid_q | ~out_stall_i);

  always_comb begin
    pix_w       = q_data_i.pixel;
    blue_d      = '0;
    green_d     = '0;
    red_d       = '0;
    alpha_d     = '0;
    has_alpha_d = 1'b0;
    unique case (fmt_q)
      pfbgr_pkg::FMT_PAL8: begin
        if (q_data_i.pal_ok) begin
          red_d   = q_data_i.rgb[23:16];
          green_d = q_data_i.rgb[15:8];
          blue_d  = q_data_i.rgb[7:0];
        end
      end
      pfbgr_pkg::FMT_RGB16: begin
        red_d   = chan16(pix_w, red_q);
        green_d = chan16(pix_w, green_q);
        blue_d  = chan16(pix_w, blue_q);
      end
      pfbgr_pkg::FMT_RGB24: begin
        pix_w   = {8'h00, q_data_i.pixel[23:0]};
        red_d   = chan_wide(pix_w, red_q);
        green_d = chan_wide(pix_w, green_q);
        blue_d  = chan_wide(pix_w, blue_q);
      end
      pfbgr_pkg::FMT_RGB32: begin
        red_d       = chan_wide(pix_w, red_q);
        green_d     = chan_wide(pix_w, green_q);
        blue_d      = chan_wide(pix_w, blue_q);
        alpha_d     = pix_w[31:24];
        has_alpha_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      blue_out_q  <= blue_d;
      green_out_q <= green_d;
      red_out_q   <= red_d;
      alpha_q     <= alpha_d;
      has_alpha_q <= has_alpha_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign blue_out_o  = blue_out_q;
  assign green_out_o = green_out_q;
  assign red_out_o   = red_out_q;
  assign alpha_out_o = alpha_q;
  assign has_alpha_o = has_alpha_q;

endmodule

### src/pixel_format_to_bgr_converter_core.sv
// Top level of the pixel format converter: front end, item queue and back end.
// Depends on pfbgr_pkg, pfbgr_front, pfbgr_queue, pfbgr_back and the macros header.
//
//   Channel  Handshake                  Beat
//   in       in_valid_i / in_stall_o    action, pixel, palette index and bytes
//   out      out_valid_o / out_stall_i  blue, green, red, alpha, has_alpha
//   cfg      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One input beat is taken every cycle unless in_stall_o is high; a conversion passes the front register,
// which holds the palette read, then a queue entry and then the back-end output register.
// A palette write yields no output beat. Reset clears control state only.
// Input stalls only when the front register holds a beat and the queue is full.
`timescale 1ns / 1ps
`include "pixel_format_to_bgr_converter_core_macros.svh"

module pixel_format_to_bgr_converter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] pixel_i,
  input  logic [7:0]  palette_index_i,
  input  logic [7:0]  palette_red_i,
  input  logic [7:0]  palette_green_i,
  input  logic [7:0]  palette_blue_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  blue_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  red_out_o,
  output logic [7:0]  alpha_out_o,
  output logic        has_alpha_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic             item_valid;
  pfbgr_pkg::item_t item;
  pfbgr_pkg::item_t q_head;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;

  pfbgr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .pixel_i        (pixel_i),
    .palette_index_i(palette_index_i),
    .palette_red_i  (palette_red_i),
    .palette_green_i(palette_green_i),
    .palette_blue_i (palette_blue_i),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .q_full_i       (q_full)
  );

  assign q_push = item_valid & ~q_full;

  pfbgr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(item),
    .pop_i      (q_pop),
    .pop_data_o (q_head),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  pfbgr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_empty_i  (q_empty),
    .q_data_i   (q_head),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .blue_out_o (blue_out_o),
    .green_out_o(green_out_o),
    .red_out_o  (red_out_o),
    .alpha_out_o(alpha_out_o),
    .has_alpha_o(has_alpha_o)
  );

  `PFBGR_ASSERT_NEVER(a_no_pop_empty, q_pop && q_empty, "queue popped while empty")
  `PFBGR_ASSERT_NEVER(a_no_push_full, q_push && q_full, "queue pushed while full")
  `PFBGR_ASSERT(a_stall_means_full, in_stall_o |-> q_full, "input stalled with room in queue")
  `PFBGR_ASSERT(a_write_no_item, (in_valid_i && !in_stall_o && action_i) |=> !item_valid, "palette write produced an item")

endmodule

### tb/pfbgr_bgra_predictor.sv
// Watches the input, output and register ports of the pixel format converter,
// predicts each BGRA beat from its own copy of the palette and registers, and compares.
// Depends on pfbgr_pkg for the format codes, register indexes and palette depth.
`timescale 1ns / 1ps

module pfbgr_bgra_predictor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        action_i,
  input  logic [31:0] pixel_i,
  input  logic [7:0]  palette_index_i,
  input  logic [7:0]  palette_red_i,
  input  logic [7:0]  palette_green_i,
  input  logic [7:0]  palette_blue_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  alpha_i,
  input  logic        has_alpha_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          mismatches_o,
  output int          outstanding_o
);

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       has_alpha;
  } bgra_t;

  pfbgr_pkg::fmt_e src_format;
  logic [31:0]     red_sel;
  logic [31:0]     green_sel;
  logic [31:0]     blue_sel;
  logic [23:0]     palette_copy [pfbgr_pkg::PALETTE_DEPTH];
  bgra_t           bgra_expected [$];
  int              mismatch_count;

  assign mismatches_o = mismatch_count;

  function automatic logic [7:0] extract_wide(logic [31:0] value, logic [31:0] sel);
    logic [31:0] field;
    int unsigned shift;
    if (sel == '0) return 8'h00;
    shift = 0;
    while (!sel[shift]) shift++;
    field = (value & sel) >> shift;
    return field[7:0];
  endfunction

  function automatic logic [7:0] extract_short(logic [31:0] value, logic [31:0] sel);
    logic [15:0] m;
    logic [15:0] field;
    int unsigned shift;
    m = sel[15:0];
    if (m == '0) return 8'h00;
    shift = 0;
    while (!m[shift]) shift++;
    field = (value[15:0] & m) >> shift;
    if ((m >> shift) == 16'h001f) return {field[4:0], 3'b000};
    return {field[5:0], 2'b00};
  endfunction

  function automatic bgra_t predict_bgra(logic [31:0] pixel);
    bgra_t r;
    r = '0;
    case (src_format)
      pfbgr_pkg::FMT_PAL8: begin
        {r.red, r.green, r.blue} = palette_copy[pixel[7:0]];
      end
      pfbgr_pkg::FMT_RGB16: begin
        r.red   = extract_short(pixel, red_sel);
        r.green = extract_short(pixel, green_sel);
        r.blue  = extract_short(pixel, blue_sel);
      end
      pfbgr_pkg::FMT_RGB24: begin
        r.red   = extract_wide({8'h00, pixel[23:0]}, red_sel);
        r.green = extract_wide({8'h00, pixel[23:0]}, green_sel);
        r.blue  = extract_wide({8'h00, pixel[23:0]}, blue_sel);
      end
      default: begin
        r.red       = extract_wide(pixel, red_sel);
        r.green     = extract_wide(pixel, green_sel);
        r.blue      = extract_wide(pixel, blue_sel);
        r.alpha     = pixel[31:24];
        r.has_alpha = 1'b1;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bgra_t want;
    if (!rst_ni) begin
      src_format = pfbgr_pkg::FMT_RGB32;
      red_sel    = 32'h000000ff;
      green_sel  = 32'h0000ff00;
      blue_sel   = 32'h00ff0000;
      bgra_expected.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (bgra_expected.size() == 0) begin
          report_mismatch("output beat with nothing pending", 0, 1);
        end else begin
          want = bgra_expected.pop_front();
          if (blue_i !== want.blue) report_mismatch("blue", want.blue, blue_i);
          if (green_i !== want.green) report_mismatch("green", want.green, green_i);
          if (red_i !== want.red) report_mismatch("red", want.red, red_i);
          if (alpha_i !== want.alpha) report_mismatch("alpha", want.alpha, alpha_i);
          if (has_alpha_i !== want.has_alpha) begin
            report_mismatch("has_alpha", want.has_alpha, has_alpha_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (action_i) begin
          palette_copy[palette_index_i] = {palette_red_i, palette_green_i, palette_blue_i};
        end else begin
          bgra_expected.push_back(predict_bgra(pixel_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pfbgr_pkg::REG_FORMAT:     src_format = pfbgr_pkg::fmt_e'(cfg_data_i[1:0]);
          pfbgr_pkg::REG_RED_MASK:   red_sel    = cfg_data_i;
          pfbgr_pkg::REG_GREEN_MASK: green_sel  = cfg_data_i;
          pfbgr_pkg::REG_BLUE_MASK:  blue_sel   = cfg_data_i;
          default: ;
        endcase
      end
      outstanding_o <= bgra_expected.size();
    end
  end

endmodule

### tb/testbench.sv
// Top of the pixel format converter testbench: clock, reset, stimulus and verdict.
// Depends on pfbgr_pkg, pixel_format_to_bgr_converter_core and pfbgr_bgra_predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int SETTLE_CYCLES = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        action;
  logic [31:0] pixel;
  logic [7:0]  palette_index;
  logic [7:0]  palette_red;
  logic [7:0]  palette_green;
  logic [7:0]  palette_blue;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic [7:0]  alpha;
  logic        has_alpha;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;
  int          mismatches;
  int          outstanding;

  pfbgr_pkg::fmt_e cur_format;
  int              burst_left;
  int              beats_sent;
  int              palette_writes;
  int              settings_used;
  bit              written [pfbgr_pkg::PALETTE_DEPTH];
  int              written_list [$];

  pixel_format_to_bgr_converter_core uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .action_i        (action),
    .pixel_i         (pixel),
    .palette_index_i (palette_index),
    .palette_red_i   (palette_red),
    .palette_green_i (palette_green),
    .palette_blue_i  (palette_blue),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .blue_out_o      (blue),
    .green_out_o     (green),
    .red_out_o       (red),
    .alpha_out_o     (alpha),
    .has_alpha_o     (has_alpha),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  pfbgr_bgra_predictor bgra_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .action_i        (action),
    .pixel_i         (pixel),
    .palette_index_i (palette_index),
    .palette_red_i   (palette_red),
    .palette_green_i (palette_green),
    .palette_blue_i  (palette_blue),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .blue_i          (blue),
    .green_i         (green),
    .red_i           (red),
    .alpha_i         (alpha),
    .has_alpha_i     (has_alpha),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .mismatches_o    (mismatches),
    .outstanding_o   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : stall_pattern
    int mode;
    int run;
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(20, 120);
      repeat (run) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ($urandom_range(0, 99) < 70);
          default: if ($urandom_range(0, 11) == 0) out_stall <= ~out_stall;
        endcase
      end
    end
  end

  task automatic send_beat(logic act, logic [31:0] pix, logic [7:0] idx,
                           logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 16);
    end
    in_valid      <= 1'b1;
    action        <= act;
    pixel         <= pix;
    palette_index <= idx;
    palette_red   <= r;
    palette_green <= g;
    palette_blue  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    beats_sent++;
    if (act) begin
      palette_writes++;
      if (!written[idx]) begin
        written[idx] = 1'b1;
        written_list.push_back(int'(idx));
      end
    end
  endtask

  task automatic convert(logic [31:0] pix);
    send_beat(1'b0, pix, 8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
  endtask

  task automatic write_entry(logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    send_beat(1'b1, $urandom(), idx, r, g, b);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic apply_setting(pfbgr_pkg::fmt_e fmt, logic [31:0] rm, logic [31:0] gm,
                               logic [31:0] bm);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= pfbgr_pkg::REG_FORMAT;
    cfg_data <= {30'd0, fmt};
    @(posedge clk);
    cfg_idx  <= pfbgr_pkg::REG_RED_MASK;
    cfg_data <= rm;
    @(posedge clk);
    cfg_idx  <= pfbgr_pkg::REG_GREEN_MASK;
    cfg_data <= gm;
    @(posedge clk);
    cfg_idx  <= pfbgr_pkg::REG_BLUE_MASK;
    cfg_data <= bm;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_format = fmt;
    settings_used++;
  endtask

  function automatic logic [31:0] random_mask(pfbgr_pkg::fmt_e fmt);
    int unsigned kind;
    int unsigned span;
    int unsigned len;
    int unsigned pos;
    logic [63:0] field;
    kind = $urandom_range(0, 19);
    span = (fmt == pfbgr_pkg::FMT_RGB16) ? 16 : (fmt == pfbgr_pkg::FMT_RGB24) ? 24 : 32;
    if (kind == 0) return '0;
    if (kind == 1) return '1;
    if (kind < 5) return $urandom();
    len   = (fmt == pfbgr_pkg::FMT_RGB16) ? $urandom_range(4, 6) : $urandom_range(1, 12);
    pos   = $urandom_range(0, span - len);
    field = ((64'd1 << len) - 64'd1) << pos;
    return field[31:0];
  endfunction

  task automatic run_random(int count);
    logic [31:0] pix;
    logic        act;
    repeat (count) begin
      if ($urandom_range(0, 199) == 0) wait_idle();
      pix = $urandom();
      act = ($urandom_range(0, 99) < 25);
      if (!act && cur_format == pfbgr_pkg::FMT_PAL8) begin
        if (written_list.size() == 0) act = 1'b1;
        else pix[7:0] = 8'(written_list[$urandom_range(0, written_list.size() - 1)]);
      end
      send_beat(act, pix, 8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
    end
  endtask

  initial begin : stimulus
    pfbgr_pkg::fmt_e fmt;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    action        <= 1'b0;
    pixel         <= '0;
    palette_index <= '0;
    palette_red   <= '0;
    palette_green <= '0;
    palette_blue  <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= pfbgr_pkg::REG_FORMAT;
    cfg_data      <= '0;
    cur_format     = pfbgr_pkg::FMT_RGB32;
    burst_left     = 0;
    beats_sent     = 0;
    palette_writes = 0;
    settings_used  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    convert(32'h00000000);
    convert(32'hffffffff);
    convert(32'h80000001);
    convert(32'ha5c30f96);
    write_entry(8'h00, 8'h00, 8'h00, 8'h00);
    write_entry(8'hff, 8'hff, 8'hff, 8'hff);
    write_entry(8'h80, 8'h12, 8'h34, 8'h56);
    write_entry(8'h01, 8'hab, 8'hcd, 8'hef);

    apply_setting(pfbgr_pkg::FMT_PAL8, 32'h000000ff, 32'h0000ff00, 32'h00ff0000);
    convert(32'hffffff00);
    convert(32'h000000ff);
    convert(32'h12345680);
    write_entry(8'h80, 8'h9a, 8'hbc, 8'hde);
    convert(32'h00000080);
    convert(32'hffffff01);

    apply_setting(pfbgr_pkg::FMT_RGB16, 32'h0000f800, 32'h000007e0, 32'h0000001f);
    convert(32'hffffffff);
    convert(32'h0000f81f);
    convert(32'hffff07e0);

    apply_setting(pfbgr_pkg::FMT_RGB16, 32'hffff0000, 32'h00000000, 32'h0000ffff);
    convert(32'hffffffff);
    convert(32'h00001234);

    apply_setting(pfbgr_pkg::FMT_RGB24, 32'hff000000, 32'h00ffffff, 32'h00800000);
    convert(32'hffffffff);
    convert(32'hff7f00ff);

    apply_setting(pfbgr_pkg::FMT_RGB32, 32'hffffffff, 32'h00000000, 32'h80000000);
    run_random($urandom_range(90, 115));
    apply_setting(pfbgr_pkg::FMT_PAL8, 32'h000000ff, 32'h0000ff00, 32'h00ff0000);
    run_random($urandom_range(90, 115));
    apply_setting(pfbgr_pkg::FMT_RGB16, 32'h00007c00, 32'h000003e0, 32'h0000001f);
    run_random($urandom_range(90, 115));
    apply_setting(pfbgr_pkg::FMT_RGB16, 32'h0000f800, 32'h000007e0, 32'h0000001f);
    run_random($urandom_range(90, 115));
    apply_setting(pfbgr_pkg::FMT_RGB24, 32'h000000ff, 32'h0000ff00, 32'h00ff0000);
    run_random($urandom_range(90, 115));
    apply_setting(pfbgr_pkg::FMT_RGB32, 32'h00ff0000, 32'h0000ff00, 32'h000000ff);
    run_random($urandom_range(90, 115));
    repeat (8) begin
      fmt = pfbgr_pkg::fmt_e'($urandom_range(0, 3));
      apply_setting(fmt, random_mask(fmt), random_mask(fmt), random_mask(fmt));
      run_random($urandom_range(90, 115));
    end

    wait_idle();
    $display("testbench: %0d beats sent, %0d of them palette writes, under %0d register settings",
             beats_sent, palette_writes, settings_used);
    $display("testbench: all four source formats, zero and full masks, 5- and 6-bit short fields");
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/pfbgr_pkg.sv
src/pfbgr_ram.sv
src/pfbgr_front.sv
src/pfbgr_queue.sv
src/pfbgr_back.sv
src/pixel_format_to_bgr_converter_core.sv
tb/pfbgr_bgra_predictor.sv
tb/testbench.sv
